[rtl/balance_safety_supervisor_assert.svh]
// ----------------------------------------------------------------------------
// balance safety supervisor assertion macros
// shared concurrent assertion forms for the supervisor checkers
// ----------------------------------------------------------------------------
`ifndef BALANCE_SAFETY_SUPERVISOR_ASSERT_SVH
`define BALANCE_SAFETY_SUPERVISOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define BSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bss check failed");

// property checked on every clock edge, reset included
`define BSS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bss check failed during or after reset");

`endif

[rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// types, codes and reset values of the balance safety supervisor
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int BSS_TIME_WIDTH = 32;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   typedef enum logic [2:0] {
      MODE_BOOT        = 3'd0,
      MODE_SELFTEST    = 3'd1,
      MODE_DISARMED    = 3'd2,
      MODE_ARMED       = 3'd3,
      MODE_REMOTE_LOST = 3'd4,
      MODE_FALLEN      = 3'd5,
      MODE_IMU_FAULT   = 3'd6,
      MODE_LOW_BATTERY = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      CMD_IMU_SAMPLE = 2'd0,
      CMD_READ_FAIL  = 2'd1,
      CMD_STALE      = 2'd2,
      CMD_INIT       = 2'd3
   } cmd_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_PITCH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TRIP_ANGLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TRIP_TIME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REARM_ANGLE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_WINDOW        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_STABLE_NEEDED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_LIMIT     = 3'd6;

   // register reset values
   localparam logic signed [15:0] RST_REFERENCE_PITCH   = 16'sd0;
   localparam logic [15:0]        RST_FALL_TRIP_ANGLE   = 16'd4500;
   localparam logic [15:0]        RST_FALL_TRIP_TIME    = 16'd500;
   localparam logic [15:0]        RST_REARM_ANGLE       = 16'd1000;
   localparam logic [15:0]        RST_ARM_WINDOW        = 16'd300;
   localparam logic [7:0]         RST_ARM_STABLE_NEEDED = 8'd50;
   localparam logic [7:0]         RST_FAILURE_LIMIT     = 8'd5;

   typedef struct packed {
      logic signed [15:0] reference_pitch;
      logic [15:0]        fall_trip_angle;
      logic [15:0]        fall_trip_time;
      logic [15:0]        rearm_angle;
      logic [15:0]        arm_window;
      logic [7:0]         arm_stable_needed;
      logic [7:0]         failure_limit;
   } bss_cfg_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [15:0] pitch;
      logic [31:0]        now_time;
      logic               neutral_seen;
      logic               remote_lost_flag;
      logic               init_ok;
   } bss_req_type;

   typedef struct packed {
      mode_type    mode;
      logic        motor_enable;
      logic [7:0]  failure_count;
   } bss_rsp_type;

endpackage

[rtl/bss_if.sv]
// ----------------------------------------------------------------------------
// bss_if
// request and response channels of the balance safety supervisor
// ----------------------------------------------------------------------------
interface bss_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic signed [15:0] pitch;
   logic [31:0]       now_time;
   logic              neutral_seen;
   logic              remote_lost_flag;
   logic              init_ok;

   modport source (output valid, command, pitch, now_time, neutral_seen,
                   remote_lost_flag, init_ok, input ready);
   modport sink   (input valid, command, pitch, now_time, neutral_seen,
                   remote_lost_flag, init_ok, output ready);
endinterface

interface bss_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       motor_enable;
   logic [7:0] failure_count;

   modport source (output valid, mode, motor_enable, failure_count, input ready);
   modport sink   (input valid, mode, motor_enable, failure_count, output ready);
endinterface

[rtl/balance_safety_supervisor.sv]
// ----------------------------------------------------------------------------
// balance_safety_supervisor
// safety mode supervisor for a self-balancing motor drive
// ----------------------------------------------------------------------------
// One request per clock cycle, sustained while responses are taken. A
// request is held in an input register, its mode update runs through the
// supervisor core, and the response lands in a result register. The rate
// rests on the state update in the core: mode, counters and fall timer are
// written back each time a request moves on, so the next request always
// sees the state the previous one left. The input side keeps taking
// requests while a response waits, and a stalled response only holds the
// pipeline once the input register is full too. There is no clearing pass
// after reset; the block is ready as soon as reset goes low. The user must
// write registers through the csr port only while nothing is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module balance_safety_supervisor
   import bss_pkg::*;
#(
   parameter int TIME_WIDTH = BSS_TIME_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   bss_req_if.sink               req_chan,
   bss_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   bss_cfg_type cfg_ff;

   // input register stage
   logic        s1_valid_ff;
   bss_req_type s1_req_ff;

   // result register stage
   logic        rsp_valid_ff, rsp_valid_in;
   bss_rsp_type rsp_ff;

   bss_req_type req_word;
   bss_rsp_type core_result;
   logic        advance;
   logic        take_req;

   // request payload gathered into one word
   always_comb begin
      req_word.command          = cmd_type'(req_chan.command);
      req_word.pitch            = req_chan.pitch;
      req_word.now_time         = req_chan.now_time;
      req_word.neutral_seen     = req_chan.neutral_seen;
      req_word.remote_lost_flag = req_chan.remote_lost_flag;
      req_word.init_ok          = req_chan.init_ok;
   end

   // the held request moves on when the result register is free or drains
   // no request is taken while reset is high
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!s1_valid_ff || advance);
   assign take_req       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_pitch   <= RST_REFERENCE_PITCH;
         cfg_ff.fall_trip_angle   <= RST_FALL_TRIP_ANGLE;
         cfg_ff.fall_trip_time    <= RST_FALL_TRIP_TIME;
         cfg_ff.rearm_angle       <= RST_REARM_ANGLE;
         cfg_ff.arm_window        <= RST_ARM_WINDOW;
         cfg_ff.arm_stable_needed <= RST_ARM_STABLE_NEEDED;
         cfg_ff.failure_limit     <= RST_FAILURE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REFERENCE_PITCH:   cfg_ff.reference_pitch   <= csr_wdata;
            CSR_FALL_TRIP_ANGLE:   cfg_ff.fall_trip_angle   <= csr_wdata;
            CSR_FALL_TRIP_TIME:    cfg_ff.fall_trip_time    <= csr_wdata;
            CSR_REARM_ANGLE:       cfg_ff.rearm_angle       <= csr_wdata;
            CSR_ARM_WINDOW:        cfg_ff.arm_window        <= csr_wdata;
            CSR_ARM_STABLE_NEEDED: cfg_ff.arm_stable_needed <= csr_wdata[7:0];
            CSR_FAILURE_LIMIT:     cfg_ff.failure_limit     <= csr_wdata[7:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, the held request starts from a known command
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_req_ff <= '0;
      end else if (take_req) begin
         s1_req_ff <= req_word;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   // mode, counters and fall timer
   bss_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .req    (s1_req_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mode          = rsp_ff.mode;
   assign rsp_chan.motor_enable  = rsp_ff.motor_enable;
   assign rsp_chan.failure_count = rsp_ff.failure_count;

endmodule

[rtl/bss_core.sv]
// ----------------------------------------------------------------------------
// bss_core
// safety mode state and its update for one request
// ----------------------------------------------------------------------------
module bss_core
   import bss_pkg::*;
#(
   parameter int TIME_WIDTH = BSS_TIME_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  bss_req_type req,
   input  bss_cfg_type cfg,
   output bss_rsp_type result
);

   mode_type              mode_ff, mode_in;
   logic [7:0]            stable_ff, stable_in;
   logic [7:0]            fail_ff, fail_in;
   logic [TIME_WIDTH-1:0] fall_start_ff, fall_start_in;
   logic                  fall_active_ff, fall_active_in;

   logic signed [16:0]    diff;
   logic [16:0]           mag;
   logic [15:0]           tilt;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] elapsed;

   assign diff    = {req.pitch[15], req.pitch} - {cfg.reference_pitch[15], cfg.reference_pitch};
   assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
   assign tilt    = mag[15:0];
   assign now_t   = TIME_WIDTH'(req.now_time);
   assign elapsed = now_t - fall_start_ff;

   // next state
   always_comb begin
      mode_in        = mode_ff;
      stable_in      = stable_ff;
      fail_in        = fail_ff;
      fall_start_in  = fall_start_ff;
      fall_active_in = fall_active_ff;
      unique case (req.command)
         CMD_IMU_SAMPLE: begin
            fail_in = '0;
            if (mode_ff != MODE_IMU_FAULT && mode_ff != MODE_LOW_BATTERY) begin
               if (tilt > cfg.fall_trip_angle) begin
                  if (!fall_active_ff) begin
                     fall_start_in  = now_t;
                     fall_active_in = 1'b1;
                  end else if (elapsed >= TIME_WIDTH'(cfg.fall_trip_time)) begin
                     mode_in = MODE_FALLEN;
                  end
               end else begin
                  fall_active_in = 1'b0;
               end
               priority if (mode_in == MODE_FALLEN) begin
                  if (tilt <= cfg.rearm_angle && req.neutral_seen) begin
                     mode_in   = MODE_DISARMED;
                     stable_in = '0;
                  end
               end else if (mode_in == MODE_DISARMED) begin
                  if (tilt <= cfg.arm_window) begin
                     if (stable_ff < cfg.arm_stable_needed) begin
                        stable_in = stable_ff + 8'd1;
                     end
                  end else begin
                     stable_in = '0;
                  end
                  if (stable_in >= cfg.arm_stable_needed && req.neutral_seen) begin
                     mode_in = MODE_ARMED;
                  end
               end else if (mode_in == MODE_ARMED && req.remote_lost_flag) begin
                  mode_in = MODE_REMOTE_LOST;
               end else if (mode_in == MODE_REMOTE_LOST && !req.remote_lost_flag) begin
                  mode_in = MODE_ARMED;
               end else begin
                  mode_in = mode_in;
               end
            end
         end
         CMD_READ_FAIL: begin
            if (fail_ff < cfg.failure_limit) begin
               fail_in = fail_ff + 8'd1;
            end
            mode_in = MODE_IMU_FAULT;
         end
         CMD_STALE: begin
            mode_in = MODE_IMU_FAULT;
         end
         CMD_INIT: begin
            mode_in = req.init_ok ? MODE_DISARMED : MODE_IMU_FAULT;
         end
      endcase
   end

   // outputs, taken after the update
   always_comb begin
      result.mode          = mode_in;
      result.motor_enable  = (mode_in == MODE_ARMED) || (mode_in == MODE_REMOTE_LOST);
      result.failure_count = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_BOOT;
         stable_ff      <= '0;
         fail_ff        <= '0;
         fall_start_ff  <= '0;
         fall_active_ff <= 1'b0;
      end else if (step) begin
         mode_ff        <= mode_in;
         stable_ff      <= stable_in;
         fail_ff        <= fail_in;
         fall_start_ff  <= fall_start_in;
         fall_active_ff <= fall_active_in;
      end
   end

endmodule

[rtl/bss_checker.sv]
// ----------------------------------------------------------------------------
// bss_checker
// port-level checks of the balance safety supervisor, bound to the top level
// ----------------------------------------------------------------------------
`include "balance_safety_supervisor_assert.svh"

module bss_checker
   import bss_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_mode,
   input logic       rsp_motor_enable,
   input logic [7:0] rsp_failure_count
);

   // motor may only run in armed or remote lost
   `BSS_ASSERT(a_motor_mode, clock, reset, rsp_valid |-> (rsp_motor_enable == ((rsp_mode == MODE_ARMED) || (rsp_mode == MODE_REMOTE_LOST))))

   // selftest and low battery are never entered
   `BSS_ASSERT(a_mode_reachable, clock, reset, rsp_valid |-> (rsp_mode != MODE_SELFTEST) && (rsp_mode != MODE_LOW_BATTERY))

   // a stalled response holds
   `BSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode) && $stable(rsp_motor_enable) && $stable(rsp_failure_count))

   // no response right after reset
   `BSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind balance_safety_supervisor bss_checker u_bss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_mode          (rsp_chan.mode),
   .rsp_motor_enable  (rsp_chan.motor_enable),
   .rsp_failure_count (rsp_chan.failure_count)
);

[sim/tb_balance_safety_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balance_safety_supervisor
// self-checking bench for the balance safety supervisor: a behavioral
// mirror of the mode, counters and fall timer predicts every status, and
// each returned status is checked field by field against it, in order,
// under directed corner cases and randomized sensor traffic with stalls
// ----------------------------------------------------------------------------
module tb_balance_safety_supervisor;
   import bss_pkg::*;

   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int RANDOM_PHASES    = 5;
   localparam int ITEMS_PER_PHASE  = 100;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bss_req_if req_if ();
   bss_rsp_if rsp_if ();

   balance_safety_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // mirror of the supervisor state and its registers
   bss_cfg_type  cfg_q;
   mode_type     mode_q;
   logic [7:0]   stable_q;
   logic [7:0]   fail_q;
   logic [31:0]  fall_start_q;
   logic         fall_active_q;

   // statuses still owed by the block, oldest first
   bss_rsp_type  expected_status_q[$];
   int           mismatches = 0;
   // random stalls on both channels, off for the closing stretch
   bit           allow_stalls = 1'b1;
   // running millisecond clock for the random traffic
   logic [31:0]  now_ms = '0;

   // ---------------------------------------------------------------------
   // status prediction
   // ---------------------------------------------------------------------

   // one event through the mirrored supervisor, returns the status after it
   function automatic bss_rsp_type advance_supervisor(input bss_req_type r);
      bss_rsp_type status;
      int          diff;
      int          tilt;
      logic [31:0] elapsed;
      case (r.command)
         CMD_IMU_SAMPLE: begin
            fail_q = '0;
            // fault and low battery ignore samples beyond the counter clear
            if (mode_q != MODE_IMU_FAULT && mode_q != MODE_LOW_BATTERY) begin
               diff = int'($signed(r.pitch)) - int'($signed(cfg_q.reference_pitch));
               tilt = (diff < 0) ? -diff : diff;
               if (tilt > int'(cfg_q.fall_trip_angle)) begin
                  // first tilted sample only starts the timer, never trips
                  if (!fall_active_q) begin
                     fall_start_q  = r.now_time;
                     fall_active_q = 1'b1;
                  end else begin
                     elapsed = r.now_time - fall_start_q;
                     if (elapsed >= {16'd0, cfg_q.fall_trip_time})
                        mode_q = MODE_FALLEN;
                  end
               end else begin
                  fall_active_q = 1'b0;
               end
               // fallen may re-arm on the very sample that tripped it
               if (mode_q == MODE_FALLEN) begin
                  if (tilt <= int'(cfg_q.rearm_angle) && r.neutral_seen) begin
                     mode_q   = MODE_DISARMED;
                     stable_q = '0;
                  end
               end else if (mode_q == MODE_DISARMED) begin
                  if (tilt <= int'(cfg_q.arm_window)) begin
                     if (stable_q < cfg_q.arm_stable_needed)
                        stable_q = stable_q + 8'd1;
                  end else begin
                     stable_q = '0;
                  end
                  if (stable_q >= cfg_q.arm_stable_needed && r.neutral_seen)
                     mode_q = MODE_ARMED;
               end else if (mode_q == MODE_ARMED && r.remote_lost_flag) begin
                  mode_q = MODE_REMOTE_LOST;
               end else if (mode_q == MODE_REMOTE_LOST && !r.remote_lost_flag) begin
                  mode_q = MODE_ARMED;
               end
            end
         end
         CMD_READ_FAIL: begin
            // saturates, and a count above a lowered limit is kept
            if (fail_q < cfg_q.failure_limit)
               fail_q = fail_q + 8'd1;
            mode_q = MODE_IMU_FAULT;
         end
         CMD_STALE: begin
            mode_q = MODE_IMU_FAULT;
         end
         default: begin
            mode_q = r.init_ok ? MODE_DISARMED : MODE_IMU_FAULT;
         end
      endcase
      status.mode          = mode_q;
      status.motor_enable  = (mode_q == MODE_ARMED || mode_q == MODE_REMOTE_LOST);
      status.failure_count = fail_q;
      return status;
   endfunction

   // mirror of one register write
   function automatic void store_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_REFERENCE_PITCH:   cfg_q.reference_pitch   = d;
         CSR_FALL_TRIP_ANGLE:   cfg_q.fall_trip_angle   = d;
         CSR_FALL_TRIP_TIME:    cfg_q.fall_trip_time    = d;
         CSR_REARM_ANGLE:       cfg_q.rearm_angle       = d;
         CSR_ARM_WINDOW:        cfg_q.arm_window        = d;
         CSR_ARM_STABLE_NEEDED: cfg_q.arm_stable_needed = d[7:0];
         CSR_FAILURE_LIMIT:     cfg_q.failure_limit     = d[7:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------

   // one request, valid is left high after acceptance so that a following
   // request goes out back to back; it drops only for a gap or a drain
   task automatic send_request(input cmd_type cmd, input logic [15:0] pitch,
                               input logic [31:0] stamp, input logic neutral,
                               input logic lost, input logic ok);
      bss_req_type r;
      r.command          = cmd;
      r.pitch            = pitch;
      r.now_time         = stamp;
      r.neutral_seen     = neutral;
      r.remote_lost_flag = lost;
      r.init_ok          = ok;
      if (allow_stalls && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.command          <= r.command;
      req_if.pitch            <= r.pitch;
      req_if.now_time         <= r.now_time;
      req_if.neutral_seen     <= r.neutral_seen;
      req_if.remote_lost_flag <= r.remote_lost_flag;
      req_if.init_ok          <= r.init_ok;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      expected_status_q.push_back(advance_supervisor(r));
   endtask

   // let everything in flight come back, then idle before returning
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write enable stays high across a run of writes
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      store_register(idx, d);
   endtask

   // full register set, plus a stray write to the unmapped index;
   // the byte-wide registers get junk in their upper byte
   task automatic apply_config(input bss_cfg_type c);
      write_register(CSR_REFERENCE_PITCH,   c.reference_pitch);
      write_register(CSR_FALL_TRIP_ANGLE,   c.fall_trip_angle);
      write_register(CSR_FALL_TRIP_TIME,    c.fall_trip_time);
      write_register(CSR_REARM_ANGLE,       c.rearm_angle);
      write_register(CSR_ARM_WINDOW,        c.arm_window);
      write_register(CSR_ARM_STABLE_NEEDED, {8'($urandom), c.arm_stable_needed});
      write_register(CSR_FAILURE_LIMIT,     {8'($urandom), c.failure_limit});
      write_register(CSR_UNMAPPED,          16'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic bss_cfg_type make_config(input int ref_pitch, input int trip_angle,
                                               input int trip_ms, input int rearm,
                                               input int window, input int needed,
                                               input int limit);
      bss_cfg_type c;
      c.reference_pitch   = 16'(ref_pitch);
      c.fall_trip_angle   = 16'(trip_angle);
      c.fall_trip_time    = 16'(trip_ms);
      c.rearm_angle       = 16'(rearm);
      c.arm_window        = 16'(window);
      c.arm_stable_needed = 8'(needed);
      c.failure_limit     = 8'(limit);
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // status checking
   // ---------------------------------------------------------------------
   initial begin : status_checker
      bss_rsp_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_status_q.size() == 0) begin
               $error("status with no request pending: mode %0d", rsp_if.mode);
               mismatches++;
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_if.mode !== want.mode) begin
                  $error("mode: expected %0d, got %0d", want.mode, rsp_if.mode);
                  mismatches++;
               end
               if (rsp_if.motor_enable !== want.motor_enable) begin
                  $error("motor_enable: expected %0d, got %0d",
                         want.motor_enable, rsp_if.motor_enable);
                  mismatches++;
               end
               if (rsp_if.failure_count !== want.failure_count) begin
                  $error("failure_count: expected %0d, got %0d",
                         want.failure_count, rsp_if.failure_count);
                  mismatches++;
               end
            end
         end
      end
   end

   // response side backpressure in random bursts
   initial begin : status_pacer
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (allow_stalls && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------

   // reset register values: trip at 4500 after 500 ms, even in boot
   task automatic test_boot_defaults();
      send_request(CMD_IMU_SAMPLE, 16'sd0,    32'd0,   1'b0, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd5000, 32'd10,  1'b1, 1'b0, 1'b0);
      // 500 ms of tilt, fallen straight out of boot
      send_request(CMD_IMU_SAMPLE, 16'sd5000, 32'd510, 1'b1, 1'b0, 1'b0);
      // level and neutral, back to disarmed
      send_request(CMD_IMU_SAMPLE, 16'sd0,    32'd600, 1'b1, 1'b0, 1'b0);
      send_request(CMD_INIT,       16'sd0,    32'd600, 1'b0, 1'b0, 1'b0);
      send_request(CMD_INIT,       16'sd0,    32'd600, 1'b0, 1'b0, 1'b1);
   endtask

   // read failures saturate, a lowered limit keeps the count, samples clear it
   task automatic test_failure_counter();
      drain_requests();
      apply_config(make_config(0, 4500, 0, 1000, 300, 2, 2));
      repeat (3) send_request(CMD_READ_FAIL, 16'sd0, 32'd0, 1'b0, 1'b0, 1'b1);
      drain_requests();
      apply_config(make_config(0, 4500, 0, 1000, 300, 2, 0));
      send_request(CMD_READ_FAIL,  16'sd0, 32'd0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_STALE,      16'sd0, 32'd0, 1'b1, 1'b1, 1'b1);
      // fault holds on a sample, the counter still clears
      send_request(CMD_IMU_SAMPLE, 16'sd0, 32'd0, 1'b1, 1'b0, 1'b0);
      send_request(CMD_READ_FAIL,  16'sd0, 32'd0, 1'b0, 1'b0, 1'b0);
   endtask

   // stable count, the neutral gate and remote link toggling
   task automatic test_arming();
      send_request(CMD_INIT,       16'sd0,    32'd0, 1'b0, 1'b0, 1'b1);
      send_request(CMD_IMU_SAMPLE, 16'sd100,  32'd0, 1'b0, 1'b0, 1'b0);
      // outside the arm window, count restarts
      send_request(CMD_IMU_SAMPLE, 16'sd400,  32'd0, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd100,  32'd0, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, -16'sd300, 32'd0, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd0,    32'd0, 1'b1, 1'b1, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd0,    32'd0, 1'b1, 1'b0, 1'b0);
   endtask

   // zero trip time, pitch extremes, clock wrap, fall and re-arm in one sample
   task automatic test_fall_timer();
      drain_requests();
      apply_config(make_config(0, 4500, 0, 1000, 300, 2, 2));
      // starting sample never trips, even with no trip time
      send_request(CMD_IMU_SAMPLE, 16'sd5000,  32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, -16'sd5000, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sh7FFF,  32'hFFFF_FFF8, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sh8000,  32'hFFFF_FFF9, 1'b1, 1'b1, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd1000,  32'hFFFF_FFFA, 1'b1, 1'b0, 1'b0);
      drain_requests();
      // elapsed time taken across the clock wrap
      apply_config(make_config(0, 4500, 32, 1000, 300, 2, 2));
      send_request(CMD_IMU_SAMPLE, 16'sd5000, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd5000, 32'h0000_000F, 1'b0, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, 16'sd5000, 32'h0000_0010, 1'b0, 1'b0, 1'b0);
      drain_requests();
      // re-arm angle above trip angle: fallen and disarmed on one sample
      apply_config(make_config(-18000, 100, 0, 36000, 0, 0, 255));
      send_request(CMD_IMU_SAMPLE, -16'sd18000, 32'd5, 1'b1, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, -16'sd17800, 32'd5, 1'b0, 1'b0, 1'b0);
      send_request(CMD_IMU_SAMPLE, -16'sd17700, 32'd5, 1'b1, 1'b0, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // random traffic
   // ---------------------------------------------------------------------

   function automatic logic [15:0] random_angle(input int typical_max);
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'd36000;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(0, typical_max));
      endcase
   endfunction

   function automatic bss_cfg_type random_config();
      bss_cfg_type c;
      case ($urandom_range(0, 9))
         0:       c.reference_pitch = -16'sd18000;
         1:       c.reference_pitch = 16'sd18000;
         2:       c.reference_pitch = 16'($urandom);
         default: c.reference_pitch = 16'(int'($urandom_range(0, 36000)) - 18000);
      endcase
      c.fall_trip_angle = random_angle(6000);
      c.rearm_angle     = random_angle(3000);
      c.arm_window      = random_angle(1500);
      case ($urandom_range(0, 9))
         0:       c.fall_trip_time = 16'd0;
         1:       c.fall_trip_time = 16'hFFFF;
         default: c.fall_trip_time = 16'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 9))
         0:       c.arm_stable_needed = 8'd0;
         1:       c.arm_stable_needed = 8'd255;
         default: c.arm_stable_needed = 8'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0:       c.failure_limit = 8'd0;
         1:       c.failure_limit = 8'd255;
         default: c.failure_limit = 8'($urandom_range(1, 6));
      endcase
      return c;
   endfunction

   // mostly plausible sample streams around the reference, with faults,
   // inits and raw noise mixed in
   task automatic test_random_traffic(input int items);
      int pick;
      int offset;
      drain_requests();
      apply_config(random_config());
      send_request(CMD_INIT, 16'($urandom), now_ms, 1'($urandom), 1'($urandom), 1'b1);
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0)
            now_ms = $urandom;
         else
            now_ms = now_ms + $urandom_range(0, cfg_q.fall_trip_time / 2 + 3);
         // recover quickly from fault and boot so sample paths get exercised
         if ((mode_q == MODE_IMU_FAULT || mode_q == MODE_BOOT) && $urandom_range(0, 2) == 0)
            send_request(CMD_INIT, 16'($urandom), now_ms, 1'($urandom), 1'($urandom),
                         ($urandom_range(0, 7) != 0));
         else if (pick < 5)
            send_request(CMD_READ_FAIL, 16'($urandom), now_ms, 1'($urandom),
                         1'($urandom), 1'($urandom));
         else if (pick < 8)
            send_request(CMD_STALE, 16'($urandom), now_ms, 1'($urandom),
                         1'($urandom), 1'($urandom));
         else if (pick < 12)
            send_request(CMD_INIT, 16'($urandom), now_ms, 1'($urandom),
                         1'($urandom), ($urandom_range(0, 3) != 0));
         else if (pick < 15)
            send_request(cmd_type'($urandom_range(0, 3)), 16'($urandom), $urandom,
                         1'($urandom), 1'($urandom), 1'($urandom));
         else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               offset = $urandom_range(0, cfg_q.arm_window);
            else if (pick < 65)
               offset = $urandom_range(0, cfg_q.rearm_angle);
            else if (pick < 90)
               offset = int'(cfg_q.fall_trip_angle) + int'($urandom_range(1, 2000));
            else
               offset = int'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 1)
               offset = -offset;
            send_request(CMD_IMU_SAMPLE,
                         16'(int'($signed(cfg_q.reference_pitch)) + offset), now_ms,
                         ($urandom_range(0, 4) != 0), ($urandom_range(0, 4) == 0),
                         1'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : test_sequence
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = '0;
      csr_wdata               = '0;
      req_if.valid            = 1'b0;
      req_if.command          = '0;
      req_if.pitch            = '0;
      req_if.now_time         = '0;
      req_if.neutral_seen     = 1'b0;
      req_if.remote_lost_flag = 1'b0;
      req_if.init_ok          = 1'b0;
      // mirror starts from the reset values
      cfg_q = make_config(RST_REFERENCE_PITCH, RST_FALL_TRIP_ANGLE, RST_FALL_TRIP_TIME,
                          RST_REARM_ANGLE, RST_ARM_WINDOW, RST_ARM_STABLE_NEEDED,
                          RST_FAILURE_LIMIT);
      mode_q        = MODE_BOOT;
      stable_q      = '0;
      fail_q        = '0;
      fall_start_q  = '0;
      fall_active_q = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_boot_defaults();
      test_failure_counter();
      test_arming();
      test_fall_timer();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // the last phase runs with both channels flowing freely
         if (phase == RANDOM_PHASES - 1)
            allow_stalls = 1'b0;
         test_random_traffic(ITEMS_PER_PHASE);
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // guard against a hung handshake
   initial begin : watchdog
      #(2_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
